>>> hw/rtl/trm_pkg.sv
`timescale 1ns / 1ps

package trm_pkg;

    localparam int DATA_W      = 32;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 11;
    localparam int S_TDATA_W   = 112;
    localparam int M_TDATA_W   = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN   = 8'd1;

    localparam logic [4:0]  REG_COUNT_RST     = 5'd16;
    localparam logic [10:0] PROG_LEN_RST      = 11'd1024;
    localparam int          STACK_LIMIT_RST   = 5;

    localparam logic [4:0] OP_ADD_REG   = 5'd0;
    localparam logic [4:0] OP_ADD_CTE   = 5'd1;
    localparam logic [4:0] OP_SUB_REG   = 5'd2;
    localparam logic [4:0] OP_SUB_CTE   = 5'd3;
    localparam logic [4:0] OP_MUL_REG   = 5'd4;
    localparam logic [4:0] OP_MUL_CTE   = 5'd5;
    localparam logic [4:0] OP_DIV_REG   = 5'd6;
    localparam logic [4:0] OP_DIV_CTE   = 5'd7;
    localparam logic [4:0] OP_LOAD      = 5'd8;
    localparam logic [4:0] OP_HALT      = 5'd9;
    localparam logic [4:0] OP_SET_LIMIT = 5'd10;
    localparam logic [4:0] OP_JUMP      = 5'd11;
    localparam logic [4:0] OP_BEQ       = 5'd12;
    localparam logic [4:0] OP_BNE       = 5'd13;
    localparam logic [4:0] OP_BLT       = 5'd14;
    localparam logic [4:0] OP_CALL      = 5'd15;
    localparam logic [4:0] OP_RET       = 5'd16;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_REG   = 3'd1;
    localparam logic [2:0] ERR_BAD_LABEL = 3'd2;
    localparam logic [2:0] ERR_DIV_ZERO  = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;
    localparam logic [2:0] ERR_EMPTY     = 3'd5;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } trm_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } trm_div_sts_t;

endpackage

>>> hw/rtl/trm_divider.sv
`timescale 1ns / 1ps

module trm_divider
    import trm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  trm_div_req_t req,
    output trm_div_sts_t sts
);

    typedef enum logic [1:0] {
        DV_IDLE = 2'b01,
        DV_RUN  = 2'b10
    } dv_state_t;

    dv_state_t            st_reg, st_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    den_reg, den_next;
    logic                 neg_reg, neg_next;

    logic [DATA_W:0]      rem_sh;
    logic [DATA_W:0]      diff;
    logic [DATA_W-1:0]    mag_a;
    logic [DATA_W-1:0]    mag_b;

    always_comb begin
        mag_a = req.dividend[DATA_W-1] ? DATA_W'(0) - req.dividend : req.dividend;
        mag_b = req.divisor[DATA_W-1] ? DATA_W'(0) - req.divisor : req.divisor;
        rem_sh = {rem_reg, quo_reg[DATA_W-1]};
        diff = rem_sh - {1'b0, den_reg};

        st_next   = st_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;

        unique case (st_reg)
            DV_IDLE: begin
                if (req.start) begin
                    st_next  = DV_RUN;
                    cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
                    rem_next = '0;
                    quo_next = mag_a;
                    den_next = mag_b;
                    neg_next = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
                end
            end
            DV_RUN: begin
                if (!diff[DATA_W]) begin
                    rem_next = diff[DATA_W-1:0];
                end else begin
                    rem_next = rem_sh[DATA_W-1:0];
                end
                quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0) begin
                    st_next   = DV_IDLE;
                    done_next = 1'b1;
                end
            end
            default: begin
                st_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= DV_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign sts.done     = done_reg;
    assign sts.quotient = neg_reg ? DATA_W'(0) - quo_reg : quo_reg;

endmodule

>>> hw/rtl/tiny_register_machine_execute.sv
`timescale 1ns / 1ps
// execute stage of a small register machine, one fetched instruction per
// s_ transfer and one result per m_ transfer, in the same order.
// s_tdata carries opcode, target, first_operand, second_operand and
// jump_address; m_tdata carries next_pc, reg_written, written_index,
// written_value, halted and error_code.
// the cfg channel writes register_count (index 0) and program_length
// (index 1); it is always ready; the user must write it only while no
// instruction is in flight, as the block itself does not enforce this.
// after the s_ transfer the instruction passes through execute and output
// load, with a division going through the 32-step serial divider between
// them; s_tready is low from the transfer until the result is loaded into
// the output register, so the block takes no new instruction before then,
// and the load waits while a stalled receiver still holds the last result.
// the register file and the return stack are local memories with
// registered reads; the register file carries a valid bit per entry.
// reset clears the register file valid bits, program counter, stack count
// and halt flag, and sets the stack limit to 5 and the config to its defaults.
// a stalled receiver holds the result in m_tdata; the next instruction may
// still be taken and waits in the output stage until the register frees.

module tiny_register_machine_execute
    import trm_pkg::*;
#(
    parameter int REG_DEPTH     = 16,
    parameter int PROGRAM_DEPTH = 1024,
    parameter int STACK_DEPTH   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // opcode, target, first_operand, second_operand, jump_address
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // next_pc, reg_written, written_index, written_value, halted, error_code
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    localparam int RI_W = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
    localparam int PC_W = $clog2(PROGRAM_DEPTH);
    localparam int SC_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LIM_RST = (STACK_LIMIT_RST < STACK_DEPTH) ? STACK_LIMIT_RST : STACK_DEPTH;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t st_reg, st_next;

    logic [PC_W-1:0]   pc_reg;
    logic              stopped_reg;
    logic [SC_W-1:0]   stk_cnt_reg;
    logic [SC_W-1:0]   stk_lim_reg;
    logic [4:0]        reg_cnt_reg;
    logic [10:0]       prog_len_reg;
    logic              m_valid_reg;
    logic [REG_DEPTH-1:0] rf_vld_reg;

    logic [4:0]        op_reg;
    logic [DATA_W-1:0] t_reg, a_reg, b_reg;
    logic [10:0]       lab_reg;

    logic [DATA_W-1:0] rf_mem [REG_DEPTH];
    logic [PC_W-1:0]   stk_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd0_reg, rd1_reg;
    logic              rd0_vld_reg, rd1_vld_reg;
    logic [PC_W-1:0]   stk_rd_reg;

    logic [PC_W-1:0]   res_pc_reg;
    logic              res_wr_reg;
    logic [RI_W-1:0]   res_idx_reg;
    logic [DATA_W-1:0] res_val_reg;
    logic              res_halt_reg;
    logic [2:0]        res_err_reg;
    logic              res_push_reg, res_pop_reg, res_setlim_reg;
    logic [SC_W-1:0]   res_lim_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [4:0]        s_op;
    logic [DATA_W-1:0] s_t, s_a, s_b;
    logic [RI_W-1:0]   ra0, ra1;
    logic [SC_W-1:0]   stk_cnt_m1;
    logic              s_fire, commit;

    logic              reg_f, cte_f, cmp_f, div_op, need_t, need_a, need_lab;
    logic [DATA_W-1:0] rlim, plim, lab32, x, r1, yy, prod;
    logic              t_ok, a_ok, b_ok, lab_ok, t_low;
    logic [PC_W-1:0]   pc_inc, lab_pc;

    logic [2:0]        ex_err;
    logic [PC_W-1:0]   ex_pc;
    logic              ex_wr, ex_halt, ex_push, ex_pop, ex_setlim, ex_div;
    logic [DATA_W-1:0] ex_val;
    logic [SC_W-1:0]   ex_lim;

    logic [DATA_W-1:0] pc32, idx32;

    trm_div_req_t div_req;
    trm_div_sts_t div_sts;

    assign s_op = s_tdata[4:0];
    assign s_t  = s_tdata[36:5];
    assign s_a  = s_tdata[68:37];
    assign s_b  = s_tdata[100:69];

    assign s_tready  = (st_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign commit    = (st_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign ra0 = s_a[RI_W-1:0];
    assign ra1 = (s_op == OP_BEQ || s_op == OP_BNE || s_op == OP_BLT) ?
                 s_t[RI_W-1:0] : s_b[RI_W-1:0];
    assign stk_cnt_m1 = stk_cnt_reg - SC_W'(1);

    // instruction decode and checks
    always_comb begin
        reg_f = (op_reg == OP_ADD_REG || op_reg == OP_SUB_REG ||
                 op_reg == OP_MUL_REG || op_reg == OP_DIV_REG);
        cte_f = (op_reg == OP_ADD_CTE || op_reg == OP_SUB_CTE ||
                 op_reg == OP_MUL_CTE || op_reg == OP_DIV_CTE);
        cmp_f = (op_reg == OP_BEQ || op_reg == OP_BNE || op_reg == OP_BLT);
        div_op = (op_reg == OP_DIV_REG || op_reg == OP_DIV_CTE);
        need_t = reg_f || cte_f || cmp_f || (op_reg == OP_LOAD);
        need_a = reg_f || cte_f || cmp_f;
        need_lab = cmp_f || (op_reg == OP_JUMP) || (op_reg == OP_CALL);

        rlim = (DATA_W'(reg_cnt_reg) < DATA_W'(REG_DEPTH)) ?
               DATA_W'(reg_cnt_reg) : DATA_W'(REG_DEPTH);
        plim = (DATA_W'(prog_len_reg) < DATA_W'(PROGRAM_DEPTH)) ?
               DATA_W'(prog_len_reg) : DATA_W'(PROGRAM_DEPTH);
        lab32 = DATA_W'(lab_reg[9:0]);
        lab_pc = lab32[PC_W-1:0];

        t_ok   = !t_reg[DATA_W-1] && (t_reg < rlim);
        a_ok   = !a_reg[DATA_W-1] && (a_reg < rlim);
        b_ok   = !b_reg[DATA_W-1] && (b_reg < rlim);
        lab_ok = !lab_reg[10] && (lab32 < plim);
        t_low  = t_reg[DATA_W-1] || (t_reg < DATA_W'(stk_cnt_reg));

        x  = rd0_vld_reg ? rd0_reg : '0;
        r1 = rd1_vld_reg ? rd1_reg : '0;
        yy = reg_f ? r1 : b_reg;
        prod = x * yy;

        pc_inc = (pc_reg == PC_W'(PROGRAM_DEPTH - 1)) ? '0 : pc_reg + PC_W'(1);
    end

    always_comb begin
        ex_err    = ERR_NONE;
        ex_pc     = pc_reg;
        ex_wr     = 1'b0;
        ex_val    = '0;
        ex_halt   = stopped_reg;
        ex_push   = 1'b0;
        ex_pop    = 1'b0;
        ex_setlim = 1'b0;
        ex_lim    = stk_lim_reg;
        ex_div    = 1'b0;
        if (!stopped_reg) begin
            priority if (need_t && !t_ok) begin
                ex_err = ERR_BAD_REG;
            end else if (need_a && !a_ok) begin
                ex_err = ERR_BAD_REG;
            end else if (reg_f && !b_ok) begin
                ex_err = ERR_BAD_REG;
            end else if (need_lab && !lab_ok) begin
                ex_err = ERR_BAD_LABEL;
            end else if (div_op && yy == '0) begin
                ex_err = ERR_DIV_ZERO;
            end else if (op_reg == OP_SET_LIMIT && t_low) begin
                ex_err = ERR_OVERFLOW;
            end else if (op_reg == OP_CALL && stk_cnt_reg >= stk_lim_reg) begin
                ex_err = ERR_OVERFLOW;
            end else if (op_reg == OP_RET && stk_cnt_reg == '0) begin
                ex_err = ERR_EMPTY;
            end else begin
                ex_err = ERR_NONE;
            end

            if (ex_err == ERR_NONE) begin
                unique case (op_reg)
                    OP_ADD_REG, OP_ADD_CTE: begin
                        ex_wr = 1'b1; ex_val = x + yy; ex_pc = pc_inc;
                    end
                    OP_SUB_REG, OP_SUB_CTE: begin
                        ex_wr = 1'b1; ex_val = x - yy; ex_pc = pc_inc;
                    end
                    OP_MUL_REG, OP_MUL_CTE: begin
                        ex_wr = 1'b1; ex_val = prod; ex_pc = pc_inc;
                    end
                    OP_DIV_REG, OP_DIV_CTE: begin
                        ex_wr = 1'b1; ex_div = 1'b1; ex_pc = pc_inc;
                    end
                    OP_LOAD: begin
                        ex_wr = 1'b1; ex_val = a_reg; ex_pc = pc_inc;
                    end
                    OP_HALT: begin
                        ex_halt = 1'b1;
                    end
                    OP_SET_LIMIT: begin
                        ex_setlim = 1'b1;
                        ex_lim = (t_reg > DATA_W'(STACK_DEPTH)) ?
                                 SC_W'(STACK_DEPTH) : t_reg[SC_W-1:0];
                        ex_pc = pc_inc;
                    end
                    OP_JUMP: begin
                        ex_pc = lab_pc;
                    end
                    OP_BEQ: begin
                        ex_pc = (r1 == x) ? lab_pc : pc_inc;
                    end
                    OP_BNE: begin
                        ex_pc = (r1 != x) ? lab_pc : pc_inc;
                    end
                    OP_BLT: begin
                        ex_pc = ($signed(r1) < $signed(x)) ? lab_pc : pc_inc;
                    end
                    OP_CALL: begin
                        ex_push = 1'b1; ex_pc = lab_pc;
                    end
                    OP_RET: begin
                        ex_pop = 1'b1; ex_pc = stk_rd_reg;
                    end
                    default: begin
                        ex_pc = pc_inc;
                    end
                endcase
            end else begin
                ex_halt = 1'b1;
            end
        end
    end

    assign div_req.start    = (st_reg == ST_EXEC) && ex_div;
    assign div_req.dividend = x;
    assign div_req.divisor  = yy;

    trm_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .sts     (div_sts)
    );

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (s_fire) st_next = ST_EXEC;
            ST_EXEC: st_next = ex_div ? ST_DIV : ST_OUT;
            ST_DIV:  if (div_sts.done) st_next = ST_OUT;
            ST_OUT:  if (commit) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            pc_reg       <= '0;
            stopped_reg  <= 1'b0;
            stk_cnt_reg  <= '0;
            stk_lim_reg  <= SC_W'(LIM_RST);
            reg_cnt_reg  <= REG_COUNT_RST;
            prog_len_reg <= PROG_LEN_RST;
            m_valid_reg  <= 1'b0;
            rf_vld_reg   <= '0;
        end else begin
            st_reg <= st_next;
            if (cfg_valid && cfg_index == CFG_REG_COUNT) begin
                reg_cnt_reg <= cfg_data[4:0];
            end
            if (cfg_valid && cfg_index == CFG_PROG_LEN) begin
                prog_len_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready && !commit) begin
                m_valid_reg <= 1'b0;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= res_pc_reg;
                stopped_reg <= res_halt_reg;
                if (res_wr_reg) begin
                    rf_vld_reg[res_idx_reg] <= 1'b1;
                end
                if (res_push_reg) begin
                    stk_cnt_reg <= stk_cnt_reg + SC_W'(1);
                end
                if (res_pop_reg) begin
                    stk_cnt_reg <= stk_cnt_m1;
                end
                if (res_setlim_reg) begin
                    stk_lim_reg <= res_lim_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg  <= s_op;
            t_reg   <= s_t;
            a_reg   <= s_a;
            b_reg   <= s_b;
            lab_reg <= s_tdata[111:101];
        end
        if (st_reg == ST_EXEC) begin
            res_pc_reg     <= ex_pc;
            res_wr_reg     <= ex_wr;
            res_idx_reg    <= ex_wr ? t_reg[RI_W-1:0] : '0;
            res_val_reg    <= ex_val;
            res_halt_reg   <= ex_halt;
            res_err_reg    <= ex_err;
            res_push_reg   <= ex_push;
            res_pop_reg    <= ex_pop;
            res_setlim_reg <= ex_setlim;
            res_lim_reg    <= ex_lim;
        end
        if (st_reg == ST_DIV && div_sts.done) begin
            res_val_reg <= div_sts.quotient;
        end
        if (commit) begin
            m_data_reg <= {5'b0, res_err_reg, res_halt_reg, res_val_reg,
                           idx32[3:0], res_wr_reg, pc32[9:0]};
        end
    end

    assign pc32  = DATA_W'(res_pc_reg);
    assign idx32 = DATA_W'(res_idx_reg);

    // register file and return stack
    always_ff @(posedge aclk) begin
        if (commit && res_wr_reg) begin
            rf_mem[res_idx_reg] <= res_val_reg;
        end
        rd0_reg     <= rf_mem[ra0];
        rd1_reg     <= rf_mem[ra1];
        rd0_vld_reg <= rf_vld_reg[ra0];
        rd1_vld_reg <= rf_vld_reg[ra1];
    end

    always_ff @(posedge aclk) begin
        if (commit && res_push_reg) begin
            stk_mem[stk_cnt_reg[SA_W-1:0]] <= pc_inc;
        end
        stk_rd_reg <= stk_mem[stk_cnt_m1[SA_W-1:0]];
    end

    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[50:48] != ERR_NONE) |-> (m_data_reg[47] && !m_data_reg[10]))
        else $error("error result without halt or with a register write");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (stk_cnt_reg <= stk_lim_reg) && (stk_lim_reg <= SC_W'(STACK_DEPTH)))
        else $error("stack count above limit");

    a_div_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DIV) |-> (res_err_reg == ERR_NONE && res_wr_reg && !res_halt_reg))
        else $error("divider running for a faulted instruction");

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("halt flag cleared");

endmodule

>>> bench/tb_tiny_register_machine_execute.sv
`timescale 1ns / 1ps

module tb_tiny_register_machine_execute;
    import trm_pkg::*;

    localparam int REG_DEPTH     = 16;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int STACK_DEPTH   = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam logic [4:0] OP_LAST = 5'd31;

    typedef enum {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [31:0] target;
        logic [31:0] first_op;
        logic [31:0] second_op;
        logic [10:0] jump_addr;
    } instr_t;

    typedef struct packed {
        logic [2:0]  error_code;
        logic        halted;
        logic [31:0] written_value;
        logic [3:0]  written_index;
        logic        reg_written;
        logic [9:0]  next_pc;
    } result_t;

    typedef struct packed {
        logic [REG_DEPTH-1:0][31:0]  regs;
        logic [STACK_DEPTH-1:0][9:0] stk;
        logic [9:0]                  pc;
        logic [4:0]                  depth;
        logic [4:0]                  limit;
        logic                        stopped;
        logic [4:0]                  reg_count;
        logic [10:0]                 prog_len;
    } mach_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;

    instr_t  instr_backlog[$];
    result_t results_due[$];
    instr_t  cur_instr;
    mach_t   arch_state;
    mach_t   plan_state;
    int      src_idle_pct = 0;
    int      sink_stall_pct = 0;
    int      n_issued = 0;
    int      n_checked = 0;
    int      n_errors = 0;
    int      n_cfg_writes = 0;
    int      n_cycles = 0;
    string   stop_kind = "nothing";

    tiny_register_machine_execute #(
        .REG_DEPTH    (REG_DEPTH),
        .PROGRAM_DEPTH(PROGRAM_DEPTH),
        .STACK_DEPTH  (STACK_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic reg_ok(logic [4:0] cnt, int v);
        int n;
        n = (cnt > REG_DEPTH) ? REG_DEPTH : cnt;
        return v >= 0 && v < n;
    endfunction

    function automatic logic label_ok(logic [10:0] len, int v);
        int n;
        n = (len > PROGRAM_DEPTH) ? PROGRAM_DEPTH : len;
        return v >= 0 && v < n;
    endfunction

    // runs one instruction against a machine state and gives its result
    function automatic void exec_instr(inout mach_t m, input instr_t in, output result_t r);
        int          t, a, b, lab, d;
        logic        reg_form, cte_form, cmp_form, take;
        logic [31:0] x, y, res, mx, my, q;
        logic [9:0]  npc, seq_pc;
        logic [2:0]  err;
        r = '0;
        if (m.stopped) begin
            r.next_pc = m.pc;
            r.halted  = 1'b1;
            return;
        end
        t   = $signed(in.target);
        a   = $signed(in.first_op);
        b   = $signed(in.second_op);
        lab = $signed(in.jump_addr);
        d   = int'(m.depth);
        reg_form = in.opcode == OP_ADD_REG || in.opcode == OP_SUB_REG ||
                   in.opcode == OP_MUL_REG || in.opcode == OP_DIV_REG;
        cte_form = in.opcode == OP_ADD_CTE || in.opcode == OP_SUB_CTE ||
                   in.opcode == OP_MUL_CTE || in.opcode == OP_DIV_CTE;
        cmp_form = in.opcode == OP_BEQ || in.opcode == OP_BNE || in.opcode == OP_BLT;
        err    = ERR_NONE;
        npc    = m.pc;
        seq_pc = m.pc + 10'd1;
        x      = '0;
        y      = '0;
        res    = '0;

        if ((reg_form || cte_form || cmp_form || in.opcode == OP_LOAD) && !reg_ok(m.reg_count, t))
            err = ERR_BAD_REG;
        else if ((reg_form || cte_form || cmp_form) && !reg_ok(m.reg_count, a))
            err = ERR_BAD_REG;
        else if (reg_form && !reg_ok(m.reg_count, b))
            err = ERR_BAD_REG;
        else if ((cmp_form || in.opcode == OP_JUMP || in.opcode == OP_CALL) &&
                 !label_ok(m.prog_len, lab))
            err = ERR_BAD_LABEL;

        if (err == ERR_NONE) begin
            if (reg_form || cte_form || cmp_form)
                x = m.regs[a[3:0]];
            if (reg_form)
                y = m.regs[b[3:0]];
            else if (cte_form)
                y = in.second_op;
            if (cmp_form)
                y = m.regs[t[3:0]];

            if (reg_form || cte_form || in.opcode == OP_LOAD) begin
                case (in.opcode)
                    OP_ADD_REG, OP_ADD_CTE: res = x + y;
                    OP_SUB_REG, OP_SUB_CTE: res = x - y;
                    OP_MUL_REG, OP_MUL_CTE: res = x * y;
                    OP_DIV_REG, OP_DIV_CTE: begin
                        if (y == '0) begin
                            err = ERR_DIV_ZERO;
                        end else begin
                            mx  = x[31] ? -x : x;
                            my  = y[31] ? -y : y;
                            q   = mx / my;
                            res = (x[31] ^ y[31]) ? -q : q;
                        end
                    end
                    default: res = in.first_op;
                endcase
                if (err == ERR_NONE) begin
                    m.regs[t[3:0]]  = res;
                    r.reg_written   = 1'b1;
                    r.written_index = t[3:0];
                    r.written_value = res;
                    npc             = seq_pc;
                end
            end else if (cmp_form) begin
                if (in.opcode == OP_BEQ)
                    take = (y == x);
                else if (in.opcode == OP_BNE)
                    take = (y != x);
                else
                    take = ($signed(y) < $signed(x));
                npc = take ? lab[9:0] : seq_pc;
            end else if (in.opcode == OP_HALT) begin
                m.stopped = 1'b1;
            end else if (in.opcode == OP_SET_LIMIT) begin
                if (t < d) begin
                    err = ERR_OVERFLOW;
                end else begin
                    m.limit = (t > STACK_DEPTH) ? 5'(STACK_DEPTH) : t[4:0];
                    npc     = seq_pc;
                end
            end else if (in.opcode == OP_JUMP) begin
                npc = lab[9:0];
            end else if (in.opcode == OP_CALL) begin
                if (d + 1 > m.limit) begin
                    err = ERR_OVERFLOW;
                end else begin
                    m.stk[m.depth[3:0]] = seq_pc;
                    m.depth             = m.depth + 5'd1;
                    npc                 = lab[9:0];
                end
            end else if (in.opcode == OP_RET) begin
                if (d == 0) begin
                    err = ERR_EMPTY;
                end else begin
                    m.depth = m.depth - 5'd1;
                    npc     = m.stk[m.depth[3:0]];
                end
            end else if (in.opcode > OP_RET) begin
                npc = seq_pc;
            end
        end

        if (err != ERR_NONE) begin
            m.stopped = 1'b1;
            npc       = m.pc;
            r.reg_written   = 1'b0;
            r.written_index = '0;
            r.written_value = '0;
        end
        m.pc         = npc;
        r.next_pc    = npc;
        r.halted     = m.stopped;
        r.error_code = err;
    endfunction

    function automatic instr_t make_instr(logic [4:0] op, logic [31:0] t, logic [31:0] a,
                                          logic [31:0] b, logic [10:0] lab);
        instr_t it;
        it.opcode    = op;
        it.target    = t;
        it.first_op  = a;
        it.second_op = b;
        it.jump_addr = lab;
        return it;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(6))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'hffff_ffff;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed instructions for the given state; unused fields are noise
    function automatic instr_t rand_instr(mach_t m);
        instr_t it;
        int     nreg, nlab, pick;
        nreg = (m.reg_count > REG_DEPTH) ? REG_DEPTH : m.reg_count;
        nlab = (m.prog_len > PROGRAM_DEPTH) ? PROGRAM_DEPTH : m.prog_len;
        it = make_instr(OP_LOAD, $urandom, pick_word(), pick_word(), 11'($urandom));
        pick = $urandom_range(99);
        if (pick < 12)
            it.opcode = OP_LOAD;
        else if (pick < 52)
            it.opcode = 5'($urandom_range(OP_DIV_CTE, OP_ADD_REG));
        else if (pick < 67)
            it.opcode = 5'($urandom_range(OP_BLT, OP_BEQ));
        else if (pick < 72)
            it.opcode = OP_JUMP;
        else if (pick < 81)
            it.opcode = OP_CALL;
        else if (pick < 90)
            it.opcode = OP_RET;
        else if (pick < 94)
            it.opcode = OP_SET_LIMIT;
        else
            it.opcode = 5'($urandom_range(OP_LAST, OP_RET + 5'd1));

        if (nreg > 0) begin
            if (it.opcode <= OP_LOAD || it.opcode == OP_BEQ || it.opcode == OP_BNE ||
                it.opcode == OP_BLT)
                it.target = $urandom_range(nreg - 1);
            if (it.opcode <= OP_DIV_CTE || it.opcode == OP_BEQ || it.opcode == OP_BNE ||
                it.opcode == OP_BLT)
                it.first_op = $urandom_range(nreg - 1);
            if (it.opcode == OP_ADD_REG || it.opcode == OP_SUB_REG ||
                it.opcode == OP_MUL_REG || it.opcode == OP_DIV_REG)
                it.second_op = $urandom_range(nreg - 1);
        end
        if (nlab > 0 && (it.opcode == OP_JUMP || it.opcode == OP_CALL ||
                         it.opcode == OP_BEQ || it.opcode == OP_BNE || it.opcode == OP_BLT))
            it.jump_addr = 11'($urandom_range(nlab - 1));
        if (it.opcode == OP_SET_LIMIT)
            it.target = ($urandom_range(7) != 0) ? m.depth + $urandom_range(12) : $urandom >> 1;
        return it;
    endfunction

    task automatic queue_item(input instr_t it);
        result_t ignored;
        exec_instr(plan_state, it, ignored);
        instr_backlog.push_back(it);
        n_issued++;
    endtask

    task automatic queue_random(input int n);
        instr_t  it;
        mach_t   trial;
        result_t r;
        int      tries;
        repeat (n) begin
            tries = 0;
            do begin
                it    = rand_instr(plan_state);
                trial = plan_state;
                exec_instr(trial, it, r);
                tries++;
            end while (r.halted && tries < 40);
            if (r.halted)
                it.opcode = OP_RET + 5'd1 + 5'($urandom_range(14));
            queue_item(it);
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (instr_backlog.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_REG_COUNT) begin
            arch_state.reg_count = val[4:0];
            plan_state.reg_count = val[4:0];
        end else if (idx == CFG_PROG_LEN) begin
            arch_state.prog_len = val;
            plan_state.prog_len = val;
        end
        n_cfg_writes++;
    endtask

    task automatic set_pace(input pace_t p);
        src_idle_pct   = (p == PACE_SRC_IDLE) ? 69 : (p == PACE_BOTH) ? 16 : 0;
        sink_stall_pct = (p == PACE_SINK_STALL) ? 69 : (p == PACE_BOTH) ? 16 : 0;
    endtask

    task automatic run_phase(input logic [10:0] rc, input logic [10:0] pl, input pace_t p,
                             input int n);
        wait_idle();
        write_cfg(CFG_REG_COUNT, rc);
        write_cfg(CFG_PROG_LEN, pl);
        set_pace(p);
        queue_random(n);
    endtask

    // an instruction sequence that stops the machine for good, its kind chosen at random
    task automatic queue_stop();
        int nreg, nlab, bad;
        nreg = (plan_state.reg_count > REG_DEPTH) ? REG_DEPTH : plan_state.reg_count;
        nlab = (plan_state.prog_len > PROGRAM_DEPTH) ? PROGRAM_DEPTH : plan_state.prog_len;
        bad  = ($urandom_range(1) != 0) ? nreg + $urandom_range(100) : -1 - $urandom_range(99);
        case ($urandom_range(6))
            0: begin
                stop_kind = "halt";
                queue_item(make_instr(OP_HALT, $urandom, $urandom, $urandom, 11'($urandom)));
            end
            1: begin
                stop_kind = "bad register";
                case ($urandom_range(2))
                    0: queue_item(make_instr(OP_SUB_REG, bad, 0, 0, 0));
                    1: queue_item(make_instr(OP_SUB_REG, 0, bad, 0, 0));
                    default: queue_item(make_instr(OP_SUB_REG, 0, 0, bad, 0));
                endcase
            end
            2: begin
                stop_kind = "bad label";
                if (nlab < PROGRAM_DEPTH && $urandom_range(1) != 0)
                    queue_item(make_instr(OP_JUMP, 0, 0, 0, 11'($urandom_range(1023, nlab))));
                else
                    queue_item(make_instr(OP_CALL, 0, 0, 0, 11'(-1 - $urandom_range(1023))));
            end
            3: begin
                stop_kind = "divide by zero";
                queue_item(make_instr(OP_DIV_CTE, 0, 0, 0, 11'($urandom)));
            end
            4: begin
                stop_kind = "stack overflow";
                if ($urandom_range(1) != 0) begin
                    queue_item(make_instr(OP_SET_LIMIT, plan_state.depth - 1, 0, 0, 0));
                end else begin
                    queue_item(make_instr(OP_SET_LIMIT, plan_state.depth, 0, 0, 0));
                    queue_item(make_instr(OP_CALL, 0, 0, 0, 0));
                end
            end
            5: begin
                stop_kind = "stack empty";
                while (plan_state.depth != 0)
                    queue_item(make_instr(OP_RET, $urandom, $urandom, $urandom, 11'($urandom)));
                queue_item(make_instr(OP_RET, $urandom, $urandom, $urandom, 11'($urandom)));
            end
            default: begin
                stop_kind = "bad register ahead of bad label";
                queue_item(make_instr(OP_BEQ, bad, bad, 0, 11'h7ff));
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_errors < 50)
            $display("mismatch on result %0d: %s got %0h expected %0h",
                     n_checked, field, got, want);
        n_errors++;
    endtask

    always @(posedge aclk) begin : feed
        result_t r;
        logic    load;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            load = 1'b0;
            if (s_tvalid && s_tready) begin
                exec_instr(arch_state, cur_instr, r);
                results_due.push_back(r);
                load = 1'b1;
            end else if (!s_tvalid) begin
                load = 1'b1;
            end
            if (load) begin
                if (instr_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_instr = instr_backlog.pop_front();
                    s_tdata  <= {cur_instr.jump_addr, cur_instr.second_op, cur_instr.first_op,
                                 cur_instr.target, cur_instr.opcode};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch
        result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected transfer", '0, '0);
                end else begin
                    want = results_due.pop_front();
                    if (got.next_pc != want.next_pc)
                        report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
                    if (got.reg_written != want.reg_written)
                        report_mismatch("reg_written", 32'(got.reg_written),
                                        32'(want.reg_written));
                    if (got.written_index != want.written_index)
                        report_mismatch("written_index", 32'(got.written_index),
                                        32'(want.written_index));
                    if (got.written_value != want.written_value)
                        report_mismatch("written_value", got.written_value, want.written_value);
                    if (got.halted != want.halted)
                        report_mismatch("halted", 32'(got.halted), 32'(want.halted));
                    if (got.error_code != want.error_code)
                        report_mismatch("error_code", 32'(got.error_code),
                                        32'(want.error_code));
                end
                n_checked++;
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", n_cycles,
                     results_due.size());
            $display("tb_tiny_register_machine_execute: done, errors");
            $finish;
        end
    end

    initial begin
        arch_state           = '0;
        arch_state.limit     = 5'(STACK_LIMIT_RST);
        arch_state.reg_count = REG_COUNT_RST;
        arch_state.prog_len  = PROG_LEN_RST;
        plan_state           = arch_state;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: operand extremes, wrap cases, every branch kind, stack round trip
        run_phase(11'd16, 11'd1024, PACE_FULL, 0);
        queue_item(make_instr(OP_LOAD, 0, 32'h7fff_ffff, $urandom, 0));
        queue_item(make_instr(OP_LOAD, 1, 32'h8000_0000, $urandom, 11'h7ff));
        queue_item(make_instr(OP_LOAD, 15, 32'hffff_ffff, 0, 0));
        queue_item(make_instr(OP_ADD_REG, 2, 0, 0, 0));
        queue_item(make_instr(OP_ADD_CTE, 3, 1, 32'h8000_0000, 0));
        queue_item(make_instr(OP_SUB_REG, 4, 1, 0, 0));
        queue_item(make_instr(OP_SUB_CTE, 5, 0, 32'hffff_ffff, 0));
        queue_item(make_instr(OP_MUL_REG, 6, 0, 0, 0));
        queue_item(make_instr(OP_MUL_CTE, 7, 1, 32'h7fff_ffff, 0));
        queue_item(make_instr(OP_DIV_CTE, 8, 1, 32'hffff_ffff, 0));
        queue_item(make_instr(OP_DIV_REG, 9, 15, 1, 0));
        queue_item(make_instr(OP_LOAD, 10, 32'hffff_fff9, 0, 0));
        queue_item(make_instr(OP_DIV_CTE, 11, 10, 32'd2, 0));
        queue_item(make_instr(OP_SET_LIMIT, 32'h7fff_ffff, 0, 0, 0));
        queue_item(make_instr(OP_BEQ, 0, 0, 0, 11'd1023));
        queue_item(make_instr(OP_BNE, 0, 0, 0, 11'd0));
        queue_item(make_instr(OP_BLT, 1, 0, 0, 11'd100));
        queue_item(make_instr(OP_CALL, $urandom, $urandom, $urandom, 11'd1023));
        queue_item(make_instr(OP_CALL, 0, 0, 0, 11'd5));
        queue_item(make_instr(OP_RET, $urandom, $urandom, $urandom, 11'h7ff));
        queue_item(make_instr(OP_RET, 0, 0, 0, 0));
        queue_item(make_instr(OP_JUMP, 32'hffff_ffff, $urandom, $urandom, 11'd512));
        queue_item(make_instr(OP_LAST, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 11'h7ff));
        queue_item(make_instr(OP_SET_LIMIT, 0, 0, 0, 0));
        queue_item(make_instr(OP_SET_LIMIT, 5, 0, 0, 0));
        queue_random(150);

        run_phase(11'd1, 11'd1, PACE_SRC_IDLE, 200);
        run_phase(11'd31, 11'd2047, PACE_SINK_STALL, 200);
        run_phase(11'd0, 11'd0, PACE_BOTH, 60);
        run_phase(11'($urandom_range(16, 1)), 11'($urandom_range(1024, 1)), PACE_FULL, 200);
        run_phase(11'd8, 11'd16, PACE_SRC_IDLE, 200);
        run_phase(11'd16, 11'd1024, PACE_SINK_STALL, 200);
        run_phase(11'($urandom_range(16, 1)), 11'($urandom_range(1024, 1)), PACE_BOTH, 200);

        // stop the machine, then confirm it ignores whatever follows
        run_phase(11'($urandom_range(16, 1)), 11'($urandom_range(1024, 1)),
                  pace_t'($urandom_range(3)), 0);
        queue_stop();
        repeat (20)
            queue_item(make_instr(5'($urandom), $urandom, $urandom, $urandom, 11'($urandom)));

        wait_idle();
        repeat (40) @(posedge aclk);
        $display("%0d instructions over %0d config writes, %0d results compared",
                 n_issued, n_cfg_writes, n_checked);
        $display("machine stopped by %s, trailing instructions checked as ignored", stop_kind);
        if (n_errors == 0)
            $display("tb_tiny_register_machine_execute: done, clean");
        else
            $display("tb_tiny_register_machine_execute: done, errors");
        $finish;
    end

endmodule

>>> tiny_register_machine_execute.f
hw/rtl/trm_pkg.sv
hw/rtl/trm_divider.sv
hw/rtl/tiny_register_machine_execute.sv
bench/tb_tiny_register_machine_execute.sv
